### design/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, suspended while reset is high.
`define NNR_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("nnr assertion failed");

// Concurrent check that also runs across reset.
`define NNR_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("nnr assertion failed");

`endif

### design/nnr_pkg.sv
// Types, constants and helpers for the Newton nth root unit.
// No dependencies; used by every module.
package nnr_pkg;

   localparam int DEF_MAX_ROOT  = 16;
   localparam int DEF_MAX_ITER  = 64;
   localparam int DEF_FRAC_BITS = 16;

   localparam int CSR_ADDR_W = 3;
   localparam logic [15:0] TOL_RESET = 16'd66;
   localparam logic REG_TOLERANCE = 1'b0;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ORDER   = 2'd1,
      ST_NEG     = 2'd2,
      ST_NOCONV  = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [4:0]         order;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] root_value;
      status_type         status;
   } rsp_item_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_INIT_WAIT, S_ITER, S_POW, S_POW_WB, S_DEN, S_DEN_WB,
      S_T1, S_T1_WB, S_T1_WAIT, S_Q_WAIT, S_UPD, S_FINISH
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'(Q_MAX)) begin
         return Q_MAX;
      end else if (v < 64'(Q_MIN)) begin
         return Q_MIN;
      end
      return v[31:0];
   endfunction

endpackage

### design/nnr_mul.sv
// Shared 32x32 signed multiplier with registered product.
// Depends on nnr_pkg (sat32).
module nnr_mul import nnr_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic signed [31:0] op_a,
   input  logic signed [31:0] op_b,
   output logic signed [31:0] q_prod,
   output logic signed [31:0] raw_sat,
   output logic signed [63:0] raw
);

   localparam logic signed [63:0] BIAS = (64'sd1 <<< FRAC_BITS) - 64'sd1;

   logic signed [63:0] prod_ff, prod_in, adj;

   assign prod_in = 64'(op_a) * 64'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // truncate toward zero before the scaling shift
   assign adj     = (prod_ff < 0) ? prod_ff + BIAS : prod_ff;
   assign q_prod  = sat32(adj >>> FRAC_BITS);
   assign raw_sat = sat32(prod_ff);
   assign raw     = prod_ff;

endmodule

### design/nnr_div.sv
// Radix-2 restoring signed divider, one quotient bit per cycle, saturating.
// Depends on nnr_pkg (Q_MIN, Q_MAX, div_sts_type).
module nnr_div import nnr_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS,
   localparam int DIV_W    = 32 + FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DIV_W-1:0] num,
   input  logic signed [31:0]      den,
   output div_sts_type             sts,
   output logic signed [31:0]      quo
);

   localparam int CNT_W = $clog2(DIV_W + 1);
   localparam logic [DIV_W-1:0] LIM = {{(DIV_W-32){1'b0}}, 32'h8000_0000};

   logic             busy_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [31:0]      rem_ff, dmag_ff, dmag;
   logic [DIV_W-1:0] acc_ff, nmag;
   logic             neg_ff, nneg_ff, zden_ff;
   logic [32:0]      rem_sh;
   logic             fits;

   assign nmag   = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
   assign dmag   = den[31] ? 32'(-den) : 32'(den);
   assign rem_sh = {rem_ff, acc_ff[DIV_W-1]};
   assign fits   = rem_sh >= {1'b0, dmag_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= (dmag != '0);
            done_ff <= (dmag == '0);
         end else if (busy_ff && cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff  <= nmag;
         dmag_ff <= dmag;
         rem_ff  <= '0;
         cnt_ff  <= CNT_W'(DIV_W);
         neg_ff  <= num[DIV_W-1] ^ den[31];
         nneg_ff <= num[DIV_W-1];
         zden_ff <= (dmag == '0);
      end else if (busy_ff) begin
         rem_ff <= fits ? 32'(rem_sh - {1'b0, dmag_ff}) : rem_sh[31:0];
         acc_ff <= {acc_ff[DIV_W-2:0], fits};
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_comb begin
      if (zden_ff) begin
         quo = nneg_ff ? Q_MIN : Q_MAX;
      end else if (neg_ff) begin
         quo = (acc_ff > LIM) ? Q_MIN : 32'(-acc_ff[31:0]);
      end else begin
         quo = (acc_ff >= LIM) ? Q_MAX : acc_ff[31:0];
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

### design/newton_nth_root_unit.sv
// Newton-Raphson nth root unit in signed fixed point (Q16.16 by default).
// Takes an item of value and order on req_, answers root and status on rsp_.
// Channels: valid/stall on both sides; an item moves when valid is high and
// stall low. req_stall is high from the accepting edge until the unit has
// handed its result to the output register, so one item is in work at a time.
// Zero value, rejected order and even root of a negative value go from the
// check state straight to finish. Otherwise one seed division (divider
// width DIV_W = 32+FRAC_BITS), then per Newton step: one setup state,
// (n-2) power multiplies, the n*x^(n-1) and (n-1)*x products, two
// divisions and one update state, for up to MAX_ITER steps. The radix-2
// divider dominates the run time.
// Tolerance register at csr addresses 0-3 (APB style, pready tied high).
// Reset: synchronous, active high; returns to idle, drops rsp_valid and sets
// the tolerance to 66 (Q0.16).
// Receiver stall: the result sits in the output register; a following item
// may be accepted and worked on, and its result waits in the finish state
// until the register is free.
module newton_nth_root_unit import nnr_pkg::*; #(
   parameter int MAX_ROOT  = DEF_MAX_ROOT,
   parameter int MAX_ITER  = DEF_MAX_ITER,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int DIV_W  = 32 + FRAC_BITS;
   localparam int ITER_W = $clog2(MAX_ITER + 1);
   localparam int PC_W   = $clog2(MAX_ROOT);
   localparam int TS_L   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int TS_R   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

   state_type state_ff, state_in;

   // csr
   logic [15:0] tol_ff;
   logic        csr_wr;
   logic [39:0] tol_s;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_TOLERANCE);
   assign csr_prdata = (csr_paddr[2] == REG_TOLERANCE) ? {16'b0, tol_ff} : '0;
   assign tol_s      = (40'(tol_ff) << TS_L) >> TS_R;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_wr) begin
         tol_ff <= csr_pwdata[15:0];
      end
   end

   // working registers
   logic signed [31:0] value_ff, value_in, x_ff, x_in, pow_ff, pow_in;
   logic signed [31:0] den_ff, den_in, t1_ff, t1_in, t2_ff, t2_in;
   logic [4:0]         n_ff, n_in;
   logic [ITER_W-1:0]  icnt_ff, icnt_in;
   logic [PC_W-1:0]    pcnt_ff, pcnt_in;
   logic signed [31:0] root_ff, root_in;
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_ff, rsp_in;

   // shared units
   logic signed [31:0] op_a, op_b, q_prod, raw_sat, quo;
   logic signed [63:0] raw;
   logic               div_start;
   logic signed [DIV_W-1:0] div_num;
   logic signed [31:0] div_den;
   div_sts_type        div_sts;

   nnr_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock(clock), .op_a(op_a), .op_b(op_b),
      .q_prod(q_prod), .raw_sat(raw_sat), .raw(raw)
   );

   nnr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(div_den), .sts(div_sts), .quo(quo)
   );

   // update step terms
   logic signed [32:0] sum;
   logic signed [31:0] x_new;
   logic [31:0]        mag_new, mag_old, diff;
   logic               converged, bad_order, even_neg, pow_last, out_free;

   assign sum       = 33'(t1_ff) + 33'(t2_ff);
   assign x_new     = sat32(64'(sum));
   assign mag_new   = x_new[31] ? 32'(-x_new) : 32'(x_new);
   assign mag_old   = x_ff[31] ? 32'(-x_ff) : 32'(x_ff);
   assign diff      = (mag_new > mag_old) ? mag_new - mag_old : mag_old - mag_new;
   assign converged = 40'(diff) < tol_s;
   assign bad_order = (n_ff < 5'd2) || (6'(n_ff) > 6'(MAX_ROOT));
   assign even_neg  = !n_ff[0] && value_ff[31];
   assign pow_last  = (6'(pcnt_ff) + 6'd1) == (6'(n_ff) - 6'd1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (req_valid) state_in = S_CHECK;
         S_CHECK: begin
            if (value_ff == '0 || bad_order || even_neg) state_in = S_FINISH;
            else state_in = S_INIT_WAIT;
         end
         S_INIT_WAIT: if (div_sts.done) state_in = S_ITER;
         S_ITER:      state_in = (n_ff == 5'd2) ? S_DEN : S_POW;
         S_POW:       state_in = S_POW_WB;
         S_POW_WB:    state_in = pow_last ? S_DEN : S_POW;
         S_DEN:       state_in = S_DEN_WB;
         S_DEN_WB:    state_in = S_T1;
         S_T1:        state_in = S_T1_WB;
         S_T1_WB:     state_in = S_T1_WAIT;
         S_T1_WAIT:   if (div_sts.done) state_in = S_Q_WAIT;
         S_Q_WAIT:    if (div_sts.done) state_in = S_UPD;
         S_UPD: begin
            if (converged || icnt_ff + ITER_W'(1) == ITER_W'(MAX_ITER)) state_in = S_FINISH;
            else state_in = S_ITER;
         end
         S_FINISH:    if (out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath and unit controls
   always_comb begin
      value_in  = value_ff;
      n_in      = n_ff;
      x_in      = x_ff;
      pow_in    = pow_ff;
      den_in    = den_ff;
      t1_in     = t1_ff;
      t2_in     = t2_ff;
      icnt_in   = icnt_ff;
      pcnt_in   = pcnt_ff;
      root_in   = root_ff;
      status_in = status_ff;
      op_a      = pow_ff;
      op_b      = x_ff;
      div_start = 1'b0;
      div_num   = DIV_W'(value_ff);
      div_den   = 32'(n_ff);
      rsp_in    = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            value_in = req_item.value;
            n_in     = req_item.order;
            icnt_in  = '0;
         end
         S_CHECK: begin
            root_in = '0;
            if (value_ff == '0) begin
               status_in = ST_OK;
            end else if (bad_order) begin
               status_in = ST_ORDER;
            end else if (even_neg) begin
               status_in = ST_NEG;
            end else begin
               div_start = 1'b1;
            end
         end
         S_INIT_WAIT: if (div_sts.done) x_in = quo;
         S_ITER: begin
            pow_in  = x_ff;
            pcnt_in = PC_W'(1);
         end
         S_POW: ;
         S_POW_WB: begin
            pow_in  = q_prod;
            pcnt_in = pcnt_ff + PC_W'(1);
         end
         S_DEN: begin
            op_a = 32'(n_ff);
            op_b = pow_ff;
         end
         S_DEN_WB: den_in = raw_sat;
         S_T1: begin
            op_a = 32'(n_ff) - 32'sd1;
            op_b = x_ff;
         end
         S_T1_WB: begin
            div_start = 1'b1;
            div_num   = raw[DIV_W-1:0];
         end
         S_T1_WAIT: begin
            div_num = {value_ff, {FRAC_BITS{1'b0}}};
            div_den = den_ff;
            if (div_sts.done) begin
               t1_in     = quo;
               div_start = 1'b1;
            end
         end
         S_Q_WAIT: if (div_sts.done) t2_in = quo;
         S_UPD: begin
            icnt_in = icnt_ff + ITER_W'(1);
            x_in    = x_new;
            if (converged) begin
               root_in   = x_new;
               status_in = ST_OK;
            end else begin
               root_in   = '0;
               status_in = ST_NOCONV;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.root_value  = root_ff;
               rsp_in.status      = status_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      n_ff      <= n_in;
      x_ff      <= x_in;
      pow_ff    <= pow_in;
      den_ff    <= den_in;
      t1_ff     <= t1_in;
      t2_ff     <= t2_in;
      icnt_ff   <= icnt_in;
      pcnt_ff   <= pcnt_in;
      root_ff   <= root_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### design/nnr_check.sv
// Port-level checker for newton_nth_root_unit, bound to the top level.
// Depends on nnr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module nnr_check import nnr_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_item
);

   `NNR_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
   `NNR_ASSERT(a_err_zero, rsp_valid && rsp_item.status != ST_OK |-> rsp_item.root_value == 0)
   `NNR_ASSERT(a_busy_after_accept, req_valid && !req_stall |=> req_stall && !$rose(rsp_valid))
   `NNR_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid && !req_stall)

endmodule

bind newton_nth_root_unit nnr_check u_nnr_check (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
);
